[rtl/core/nes_pkg.sv]
// shared types, constants and helpers of the note event scheduler
`timescale 1ns / 1ps
`default_nettype none
package nes_pkg;

  localparam int TimeW  = 48;
  localparam int KeyW   = 15;
  localparam int EventW = 38;
  localparam int MsgMax = 32;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_PLAY    = 2'd1,
    OP_DELAYED = 2'd2,
    OP_NONE    = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REL_SCAN,
    ST_DLY_SCAN,
    ST_DLY_RET,
    ST_PARK,
    ST_PN_ON,
    ST_PN_SCAN,
    ST_PN_WRITE,
    ST_FINISH
  } state_t;

  localparam logic KIND_ON  = 1'b0;
  localparam logic KIND_OFF = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] patch;
    logic [6:0] note;
    logic [6:0] vel;
  } msg_t;

  // time plus a millisecond count, wrapping on 48 bits
  function automatic logic [TimeW-1:0] add_ms(input logic [TimeW-1:0] t,
                                              input logic [15:0] ms);
    logic [25:0] us;
    us = 26'(ms) * 26'd1000;
    return t + TimeW'(us);
  endfunction

endpackage
`default_nettype wire

[rtl/core/nes_cell.sv]
// one slot cell of a rotating slot ring
`timescale 1ns / 1ps
`default_nettype none
module nes_cell #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         shift,
  input  wire logic         d_valid,
  input  wire logic [W-1:0] d_data,
  output logic              q_valid,
  output logic [W-1:0]      q_data
);

  // valid bit, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (shift) begin
      q_valid <= d_valid;
    end
  end

  // slot contents
  always_ff @(posedge clk) begin
    if (shift) begin
      q_data <= d_data;
    end
  end

endmodule
`default_nettype wire

[rtl/core/nes_ring.sv]
// ring of slot cells that rotates one place towards the head per shift
`timescale 1ns / 1ps
`default_nettype none
module nes_ring #(
  parameter int N = 16,
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         shift,
  input  wire logic         tail_valid,
  input  wire logic [W-1:0] tail_data,
  output logic              head_valid,
  output logic [W-1:0]      head_data
);

  logic         v [N];
  logic [W-1:0] d [N];

  // each cell takes its upper neighbour, the last one takes the tail input
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic         in_v;
    logic [W-1:0] in_d;
    if (i == N - 1) begin : g_last
      assign in_v = tail_valid;
      assign in_d = tail_data;
    end else begin : g_mid
      assign in_v = v[i+1];
      assign in_d = d[i+1];
    end
    nes_cell #(.W(W)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (shift),
      .d_valid (in_v),
      .d_data  (in_d),
      .q_valid (v[i]),
      .q_data  (d[i])
    );
  end

  assign head_valid = v[0];
  assign head_data  = d[0];

endmodule
`default_nettype wire

[rtl/core/note_event_scheduler.sv]
// top level: note event scheduler with release and delay slot rings
//
// Input requests carry an opcode (tick, play now, play delayed), the current
// time in microseconds and the note. A request is taken when in_valid is high
// and in_stall low; in_stall stays high while a request is being worked on.
// Messages (note-on / note-off) leave on the output channel, taken when
// out_valid is high and out_stall low; last_of_run marks the final message
// of a request. A request may give no message at all.
// Both slot tables are rings of cells rotating one place per shift, so every
// walk over a table visits the slots one by one. With output_enable set, play
// now sends the note-on and walks the release ring twice, to find a slot and
// then to write the note; play delayed walks the delay ring to park the note,
// or plays it now when no delay slot is free; tick walks the release ring,
// then the delay ring, and plays each delay slot that falls due; the unused
// opcode none does nothing. A stall on the output holds the walk once a
// finished message and one behind it are held. Reset (synchronous, rst high)
// clears all slots and output_enable at once. output_enable is to be written
// through cfg_write_en / cfg_write_data while idle; the block does not check.
`timescale 1ns / 1ps
`default_nettype none
module note_event_scheduler #(
  parameter int RELEASE_SLOTS = 16,
  parameter int DELAY_SLOTS   = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write_en,
  input  wire logic        cfg_write_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [47:0] time_us,
  input  wire logic [7:0]  patch_index,
  input  wire logic [6:0]  note_pitch,
  input  wire logic [6:0]  note_velocity,
  input  wire logic [15:0] hold_ms,
  input  wire logic [15:0] wait_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             message_kind,
  output logic [7:0]       out_patch,
  output logic [6:0]       out_note,
  output logic [6:0]       out_velocity,
  output logic             last_of_run
);

  localparam int TW  = nes_pkg::TimeW;
  localparam int KW  = nes_pkg::KeyW;
  localparam int EW  = nes_pkg::EventW;
  localparam int RPW = (RELEASE_SLOTS > 1) ? $clog2(RELEASE_SLOTS) : 1;
  localparam int DPW = (DELAY_SLOTS > 1) ? $clog2(DELAY_SLOTS) : 1;
  localparam logic [RPW-1:0] RLast = RPW'(RELEASE_SLOTS - 1);
  localparam logic [DPW-1:0] DLast = DPW'(DELAY_SLOTS - 1);

  nes_pkg::state_t state, state_next;

  logic          output_enable;
  logic [TW-1:0] now;
  logic [7:0]    req_patch;
  logic [6:0]    req_note;
  logic [6:0]    req_vel;
  logic [15:0]   req_hold;
  logic [TW-1:0] wait_dl;
  logic [KW-1:0] cur_key;
  logic [6:0]    cur_vel;
  logic [15:0]   cur_hold;
  logic [TW-1:0] pn_dl;
  logic          from_tick;
  logic          placed;
  logic          match_f, free_f;
  logic [RPW-1:0] match_idx, free_idx, rpos;
  logic [DPW-1:0] dpos;
  logic [5:0]    msg_cnt;

  // ring ports
  logic             r_shift, r_tail_v, rh_v;
  logic [KW+TW-1:0] r_tail_d, rh_d;
  logic             d_shift, d_tail_v, dh_v;
  logic [EW+TW-1:0] d_tail_d, dh_d;

  logic [KW-1:0] rh_key;
  logic [TW-1:0] rh_dl;
  logic [EW-1:0] dh_ev;
  logic [TW-1:0] dh_dl;
  assign rh_key = rh_d[KW+TW-1:TW];
  assign rh_dl  = rh_d[TW-1:0];
  assign dh_ev  = dh_d[EW+TW-1:TW];
  assign dh_dl  = dh_d[TW-1:0];

  // message staging: pend waits until its successor or the end is known
  logic          pend_v;
  nes_pkg::msg_t pend;
  logic          out_free, can_emit, drop, emit_ok;
  logic          want, push, step, flush;
  nes_pkg::msg_t msg;

  assign out_free = !out_valid || !out_stall;
  assign can_emit = !pend_v || out_free;
  assign drop     = (msg_cnt == 6'(nes_pkg::MsgMax));
  assign emit_ok  = drop || can_emit;
  assign push     = want && !drop && can_emit;
  assign in_stall = (state != nes_pkg::ST_IDLE);

  logic accept;
  assign accept = in_valid && !in_stall;

  logic rel_exp, dly_due, park_free, steal, hit;
  logic [RPW-1:0] tgt;
  assign rel_exp   = rh_v && (now >= rh_dl);
  assign dly_due   = dh_v && (now >= dh_dl);
  assign park_free = !dh_v && !placed;
  assign steal     = !match_f && !free_f;
  assign tgt       = match_f ? match_idx : (free_f ? free_idx : '0);
  assign hit       = (rpos == tgt);

  nes_ring #(.N(RELEASE_SLOTS), .W(KW + TW)) u_rel (
    .clk        (clk),
    .rst        (rst),
    .shift      (r_shift),
    .tail_valid (r_tail_v),
    .tail_data  (r_tail_d),
    .head_valid (rh_v),
    .head_data  (rh_d)
  );

  nes_ring #(.N(DELAY_SLOTS), .W(EW + TW)) u_dly (
    .clk        (clk),
    .rst        (rst),
    .shift      (d_shift),
    .tail_valid (d_tail_v),
    .tail_data  (d_tail_d),
    .head_valid (dh_v),
    .head_data  (dh_d)
  );

  // sequencer outputs
  always_comb begin
    r_shift  = 1'b0;
    r_tail_v = rh_v;
    r_tail_d = rh_d;
    d_shift  = 1'b0;
    d_tail_v = dh_v;
    d_tail_d = dh_d;
    want     = 1'b0;
    msg      = '{kind: nes_pkg::KIND_OFF, patch: rh_key[14:7], note: rh_key[6:0], vel: 7'd0};
    step     = 1'b1;
    flush    = 1'b0;
    unique case (state)
      nes_pkg::ST_IDLE: begin
      end
      nes_pkg::ST_REL_SCAN: begin
        want     = rel_exp && output_enable;
        step     = !want || emit_ok;
        r_shift  = step;
        r_tail_v = rh_v && !rel_exp;
      end
      nes_pkg::ST_DLY_SCAN: begin
        d_shift = !dly_due;
      end
      nes_pkg::ST_DLY_RET: begin
        d_shift  = 1'b1;
        d_tail_v = 1'b0;
      end
      nes_pkg::ST_PARK: begin
        d_shift = 1'b1;
        if (park_free) begin
          d_tail_v = 1'b1;
          d_tail_d = {req_hold, req_vel, req_patch, req_note, wait_dl};
        end
      end
      nes_pkg::ST_PN_ON: begin
        want = output_enable;
        msg  = '{kind: nes_pkg::KIND_ON, patch: cur_key[14:7], note: cur_key[6:0],
                 vel: cur_vel};
        step = !want || emit_ok;
      end
      nes_pkg::ST_PN_SCAN: begin
        r_shift = 1'b1;
      end
      nes_pkg::ST_PN_WRITE: begin
        want    = steal && (rpos == '0);
        step    = !want || emit_ok;
        r_shift = step;
        if (hit) begin
          r_tail_v = 1'b1;
          r_tail_d = {cur_key, pn_dl};
        end
      end
      nes_pkg::ST_FINISH: begin
        flush = pend_v && out_free;
        step  = !pend_v || out_free;
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      nes_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (nes_pkg::opcode_t'(opcode))
            nes_pkg::OP_TICK:    state_next = nes_pkg::ST_REL_SCAN;
            nes_pkg::OP_PLAY:    state_next = nes_pkg::ST_PN_ON;
            nes_pkg::OP_DELAYED: state_next = nes_pkg::ST_PARK;
            nes_pkg::OP_NONE:    state_next = nes_pkg::ST_IDLE;
            default:             state_next = nes_pkg::ST_IDLE;
          endcase
        end
      end
      nes_pkg::ST_REL_SCAN: begin
        if (step && rpos == RLast) state_next = nes_pkg::ST_DLY_SCAN;
      end
      nes_pkg::ST_DLY_SCAN: begin
        if (dly_due) state_next = nes_pkg::ST_PN_ON;
        else if (dpos == DLast) state_next = nes_pkg::ST_FINISH;
      end
      nes_pkg::ST_DLY_RET: begin
        state_next = (dpos == DLast) ? nes_pkg::ST_FINISH : nes_pkg::ST_DLY_SCAN;
      end
      nes_pkg::ST_PARK: begin
        if (dpos == DLast) begin
          state_next = (placed || park_free) ? nes_pkg::ST_FINISH : nes_pkg::ST_PN_ON;
        end
      end
      nes_pkg::ST_PN_ON: begin
        if (!output_enable) begin
          state_next = from_tick ? nes_pkg::ST_DLY_RET : nes_pkg::ST_FINISH;
        end else if (step) begin
          state_next = nes_pkg::ST_PN_SCAN;
        end
      end
      nes_pkg::ST_PN_SCAN: begin
        if (rpos == RLast) state_next = nes_pkg::ST_PN_WRITE;
      end
      nes_pkg::ST_PN_WRITE: begin
        if (step && rpos == RLast) begin
          state_next = from_tick ? nes_pkg::ST_DLY_RET : nes_pkg::ST_FINISH;
        end
      end
      nes_pkg::ST_FINISH: begin
        if (step) state_next = nes_pkg::ST_IDLE;
      end
      default: state_next = nes_pkg::ST_IDLE;
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= nes_pkg::ST_IDLE;
      output_enable <= 1'b0;
      rpos          <= '0;
      dpos          <= '0;
      pend_v        <= 1'b0;
      out_valid     <= 1'b0;
      msg_cnt       <= '0;
    end else begin
      state <= state_next;
      if (cfg_write_en) output_enable <= cfg_write_data;
      if (r_shift) rpos <= (rpos == RLast) ? '0 : rpos + 1'b1;
      if (d_shift) dpos <= (dpos == DLast) ? '0 : dpos + 1'b1;
      if (accept) msg_cnt <= '0;
      else if (push) msg_cnt <= msg_cnt + 1'b1;
      // output register and staging
      if (push) begin
        pend_v <= 1'b1;
        if (pend_v) out_valid <= 1'b1;
        else if (!out_stall) out_valid <= 1'b0;
      end else if (flush) begin
        pend_v    <= 1'b0;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // message payload registers
  always_ff @(posedge clk) begin
    if (push) begin
      pend <= msg;
      if (pend_v) begin
        {message_kind, out_patch, out_note, out_velocity} <= pend;
        last_of_run <= 1'b0;
      end
    end else if (flush) begin
      {message_kind, out_patch, out_note, out_velocity} <= pend;
      last_of_run <= 1'b1;
    end
  end

  // request and play registers
  always_ff @(posedge clk) begin
    if (accept) begin
      now       <= time_us;
      req_patch <= patch_index;
      req_note  <= note_pitch;
      req_vel   <= note_velocity;
      req_hold  <= hold_ms;
      wait_dl   <= nes_pkg::add_ms(time_us, wait_ms);
      cur_key   <= {patch_index, note_pitch};
      cur_vel   <= note_velocity;
      cur_hold  <= hold_ms;
      from_tick <= (opcode == nes_pkg::OP_TICK);
      placed    <= 1'b0;
    end
    if (state == nes_pkg::ST_PARK && park_free) placed <= 1'b1;
    if (state == nes_pkg::ST_DLY_SCAN && dly_due) begin
      cur_key  <= dh_ev[KW-1:0];
      cur_vel  <= dh_ev[21:15];
      cur_hold <= dh_ev[37:22];
    end
    if (state == nes_pkg::ST_PN_ON) begin
      pn_dl   <= nes_pkg::add_ms(now, cur_hold);
      match_f <= 1'b0;
      free_f  <= 1'b0;
    end
    if (state == nes_pkg::ST_PN_SCAN) begin
      if (rh_v && rh_key == cur_key && !match_f) begin
        match_f   <= 1'b1;
        match_idx <= rpos;
      end
      if (!rh_v && !free_f) begin
        free_f   <= 1'b1;
        free_idx <= rpos;
      end
    end
  end

endmodule
`default_nettype wire

[tb/tb_note_event_scheduler.sv]
// self-checking testbench for the note event scheduler
`timescale 1ns / 1ps
module tb_note_event_scheduler;

  localparam int RelSlots  = 16;
  localparam int DlySlots  = 8;
  localparam int HoldOff   = 400;
  localparam int IdleLimit = 20000;
  localparam int RandItems = 220;

  typedef struct packed {
    nes_pkg::msg_t m;
    logic last;
  } note_msg_t;

  typedef struct {
    logic       en;
    nes_pkg::opcode_t op;
    logic [47:0] t;
    logic [7:0] p;
    logic [6:0] n;
    logic [6:0] v;
    logic [15:0] h;
    logic [15:0] w;
    int         typed;  // -1 from predictor, 0 no message, 1 one message given
    nes_pkg::msg_t m;
  } row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic        cfg_write_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  opcode = nes_pkg::OP_TICK;
  logic [47:0] time_us = '0;
  logic [7:0]  patch_index = '0;
  logic [6:0]  note_pitch = '0;
  logic [6:0]  note_velocity = '0;
  logic [15:0] hold_ms = '0;
  logic [15:0] wait_ms = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        message_kind;
  logic [7:0]  out_patch;
  logic [6:0]  out_note;
  logic [6:0]  out_velocity;
  logic        last_of_run;

  note_event_scheduler #(.RELEASE_SLOTS(RelSlots), .DELAY_SLOTS(DlySlots)) DUT (
    .clk(clk), .rst(rst), .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_stall(in_stall), .opcode(opcode), .time_us(time_us),
    .patch_index(patch_index), .note_pitch(note_pitch), .note_velocity(note_velocity),
    .hold_ms(hold_ms), .wait_ms(wait_ms), .out_valid(out_valid), .out_stall(out_stall),
    .message_kind(message_kind), .out_patch(out_patch), .out_note(out_note),
    .out_velocity(out_velocity), .last_of_run(last_of_run)
  );

  // clock, 4 ns period
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // scheduler model state
  logic        synth_on;
  logic        rel_valid [RelSlots];
  logic [14:0] rel_key [RelSlots];
  logic [47:0] rel_due [RelSlots];
  logic        dly_valid [DlySlots];
  logic [37:0] dly_event [DlySlots];
  logic [47:0] dly_due [DlySlots];
  note_msg_t   run_msgs[$];
  note_msg_t   pending_msgs[$];
  int          errors = 0;
  int          idle_cycles = 0;

  function automatic logic [47:0] due_time(logic [47:0] t, logic [15:0] ms);
    logic [63:0] sum;
    sum = {16'b0, t} + {48'b0, ms} * 64'd1000;
    return sum[47:0];
  endfunction

  function automatic void push_msg(logic kind, logic [7:0] p, logic [6:0] n, logic [6:0] v);
    note_msg_t x;
    if (run_msgs.size() < nes_pkg::MsgMax) begin
      x.m = '{kind: kind, patch: p, note: n, vel: v};
      x.last = 1'b0;
      run_msgs.push_back(x);
    end
  endfunction

  function automatic void sound_note(logic [47:0] t, logic [7:0] p, logic [6:0] n,
                                     logic [6:0] v, logic [15:0] h);
    int slot;
    slot = -1;
    if (!synth_on) return;
    push_msg(nes_pkg::KIND_ON, p, n, v);
    for (int i = 0; i < RelSlots; i++) begin
      if (rel_valid[i] && rel_key[i] == {p, n}) begin
        slot = i;
        break;
      end
      if (!rel_valid[i] && slot < 0) slot = i;
    end
    // table full: steal slot 0
    if (slot < 0) begin
      slot = 0;
      push_msg(nes_pkg::KIND_OFF, rel_key[0][14:7], rel_key[0][6:0], 7'd0);
    end
    rel_valid[slot] = 1'b1;
    rel_key[slot] = {p, n};
    rel_due[slot] = due_time(t, h);
  endfunction

  function automatic void schedule_request(nes_pkg::opcode_t op, logic [47:0] t,
                                           logic [7:0] p, logic [6:0] n, logic [6:0] v,
                                           logic [15:0] h, logic [15:0] w);
    logic parked;
    parked = 1'b0;
    run_msgs.delete();
    case (op)
      nes_pkg::OP_TICK: begin
        for (int i = 0; i < RelSlots; i++) begin
          if (rel_valid[i] && t >= rel_due[i]) begin
            if (synth_on) begin
              push_msg(nes_pkg::KIND_OFF, rel_key[i][14:7], rel_key[i][6:0], 7'd0);
            end
            rel_valid[i] = 1'b0;
          end
        end
        for (int i = 0; i < DlySlots; i++) begin
          if (dly_valid[i] && t >= dly_due[i]) begin
            sound_note(t, dly_event[i][14:7], dly_event[i][6:0], dly_event[i][21:15],
                       dly_event[i][37:22]);
            dly_valid[i] = 1'b0;
          end
        end
      end
      nes_pkg::OP_PLAY: sound_note(t, p, n, v, h);
      nes_pkg::OP_DELAYED: begin
        for (int i = 0; i < DlySlots; i++) begin
          if (!parked && !dly_valid[i]) begin
            dly_valid[i] = 1'b1;
            dly_event[i] = {h, v, p, n};
            dly_due[i] = due_time(t, w);
            parked = 1'b1;
          end
        end
        if (!parked) sound_note(t, p, n, v, h);
      end
      default: ;
    endcase
    if (run_msgs.size() > 0) run_msgs[run_msgs.size()-1].last = 1'b1;
  endfunction

  // present one request and wait for it to be taken
  task automatic send_request(nes_pkg::opcode_t op, logic [47:0] t, logic [7:0] p,
                              logic [6:0] n, logic [6:0] v, logic [15:0] h,
                              logic [15:0] w, int typed, nes_pkg::msg_t m);
    note_msg_t x;
    in_valid <= 1'b1;
    opcode <= op;
    time_us <= t;
    patch_index <= p;
    note_pitch <= n;
    note_velocity <= v;
    hold_ms <= h;
    wait_ms <= w;
    do @(posedge clk); while (in_stall);
    schedule_request(op, t, p, n, v, h, w);
    if (typed < 0) begin
      foreach (run_msgs[i]) pending_msgs.push_back(run_msgs[i]);
    end else if (typed == 1) begin
      x.m = m;
      x.last = 1'b1;
      pending_msgs.push_back(x);
    end
    // random gap after a burst
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // write output_enable once the block has drained
  task automatic set_synth(logic en);
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (pending_msgs.size() != 0) @(posedge clk);
    repeat (HoldOff) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= en;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    synth_on = en;
  endtask

  row_t rows [] = '{
    '{1'b0, nes_pkg::OP_PLAY,    48'd1000, 8'd5, 7'd60, 7'd100, 16'd10, 16'd0, 0, '0},
    '{1'b0, nes_pkg::OP_DELAYED, 48'd1000, 8'd6, 7'd61, 7'd90,  16'd10, 16'd0, 0, '0},
    '{1'b0, nes_pkg::OP_TICK,    48'd2000, 8'd0, 7'd0,  7'd0,   16'd0,  16'd0, 0, '0},
    '{1'b1, nes_pkg::OP_PLAY,    48'd0, 8'd255, 7'd127, 7'd127, 16'd0, 16'd0, 1,
      '{nes_pkg::KIND_ON, 8'd255, 7'd127, 7'd127}},
    '{1'b1, nes_pkg::OP_TICK,    48'd0, 8'd0, 7'd0, 7'd0, 16'd0, 16'd0, 1,
      '{nes_pkg::KIND_OFF, 8'd255, 7'd127, 7'd0}},
    '{1'b1, nes_pkg::OP_NONE,    48'd0, 8'd3, 7'd3, 7'd3, 16'd3, 16'd3, 0, '0},
    '{1'b1, nes_pkg::OP_PLAY,    48'd0, 8'd0, 7'd0, 7'd0, 16'hFFFF, 16'd0, 1,
      '{nes_pkg::KIND_ON, 8'd0, 7'd0, 7'd0}},
    '{1'b1, nes_pkg::OP_PLAY,    48'd5, 8'd0, 7'd0, 7'd1, 16'd1, 16'd0, 1,
      '{nes_pkg::KIND_ON, 8'd0, 7'd0, 7'd1}},
    '{1'b1, nes_pkg::OP_TICK,    48'd1004, 8'd0, 7'd0, 7'd0, 16'd0, 16'd0, -1, '0},
    '{1'b1, nes_pkg::OP_TICK,    48'd1005, 8'd0, 7'd0, 7'd0, 16'd0, 16'd0, 1,
      '{nes_pkg::KIND_OFF, 8'd0, 7'd0, 7'd0}},
    '{1'b1, nes_pkg::OP_PLAY, 48'hFFFF_FFFF_FFFF, 8'd1, 7'd2, 7'd3, 16'hFFFF, 16'd0, 1,
      '{nes_pkg::KIND_ON, 8'd1, 7'd2, 7'd3}},
    '{1'b1, nes_pkg::OP_TICK,    48'd10, 8'd0, 7'd0, 7'd0, 16'd0, 16'd0, -1, '0},
    '{1'b1, nes_pkg::OP_TICK,    48'd65535000, 8'd0, 7'd0, 7'd0, 16'd0, 16'd0, -1, '0},
    '{1'b1, nes_pkg::OP_DELAYED, 48'd100, 8'd7, 7'd8, 7'd9, 16'd1, 16'd0, 0, '0},
    '{1'b1, nes_pkg::OP_DELAYED, 48'd100, 8'd9, 7'd9, 7'd9, 16'd1, 16'hFFFF, 0, '0},
    '{1'b1, nes_pkg::OP_TICK,    48'd100, 8'd0, 7'd0, 7'd0, 16'd0, 16'd0, -1, '0},
    '{1'b1, nes_pkg::OP_TICK,    48'd1100, 8'd0, 7'd0, 7'd0, 16'd0, 16'd0, -1, '0},
    '{1'b1, nes_pkg::OP_NONE, 48'hFFFF_FFFF_FFFF, 8'd255, 7'd127, 7'd127, 16'hFFFF,
      16'hFFFF, 0, '0}
  };

  // stimulus
  initial begin
    logic [47:0] now;
    logic [7:0]  p;
    logic [6:0]  n;
    logic [15:0] h;
    logic [15:0] w;
    int          pick;
    nes_pkg::opcode_t op;
    synth_on = 1'b0;
    foreach (rel_valid[i]) begin
      rel_valid[i] = 1'b0; rel_key[i] = '0; rel_due[i] = '0;
    end
    foreach (dly_valid[i]) begin
      dly_valid[i] = 1'b0; dly_event[i] = '0; dly_due[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (rows[i]) begin
      if (rows[i].en != synth_on) set_synth(rows[i].en);
      send_request(rows[i].op, rows[i].t, rows[i].p, rows[i].n, rows[i].v, rows[i].h,
                   rows[i].w, rows[i].typed, rows[i].m);
    end

    // random phases, mostly play and tick on a small key pool with a rising clock
    now = 48'd2_000_000;
    for (int ph = 0; ph < 5; ph++) begin
      set_synth(ph == 2 ? 1'b0 : 1'b1);
      for (int k = 0; k < RandItems / 5; k++) begin
        pick = $urandom_range(0, 99);
        op = pick < 30 ? nes_pkg::OP_TICK : pick < 68 ? nes_pkg::OP_PLAY :
             pick < 95 ? nes_pkg::OP_DELAYED : nes_pkg::OP_NONE;
        case ($urandom_range(0, 19))
          0: now = 48'({$urandom, $urandom});
          1: now = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 3000000));
          default: now = now + 48'($urandom_range(0, 40000));
        endcase
        if ($urandom_range(0, 3) == 0) begin
          p = 8'($urandom); n = 7'($urandom);
        end else begin
          p = $urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(0, 3));
          n = 7'($urandom_range(0, 20));
        end
        h = $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(0, 60));
        w = $urandom_range(0, 4) == 0 ? 16'($urandom) : 16'($urandom_range(0, 60));
        send_request(op, now, p, n, 7'($urandom), h, w, -1, '0);
      end
    end
    in_valid <= 1'b0;
    while (pending_msgs.size() != 0) @(posedge clk);
    repeat (HoldOff) @(posedge clk);
    if (errors == 0) begin
      $display("tb_note_event_scheduler OK");
    end else begin
      $display("tb_note_event_scheduler NOT OK");
    end
    $finish;
  end

  // receiver stall pattern: none, sparse, long runs
  int stall_run = 0;
  int cyc = 0;
  always @(posedge clk) begin
    cyc++;
    case ((cyc >> 8) % 3)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: begin
        if (stall_run > 0) begin
          stall_run--;
          out_stall <= 1'b1;
        end else if ($urandom_range(0, 15) == 0) begin
          stall_run = $urandom_range(1, 20);
          out_stall <= 1'b1;
        end else begin
          out_stall <= 1'b0;
        end
      end
    endcase
  end

  // message checker
  always @(posedge clk) begin
    note_msg_t x;
    if (!rst && out_valid && !out_stall) begin
      if (pending_msgs.size() == 0) begin
        $error("unexpected message kind=%0d patch=%0d note=%0d", message_kind, out_patch,
               out_note);
        errors++;
      end else begin
        x = pending_msgs.pop_front();
        if (message_kind !== x.m.kind) begin
          $error("message_kind expected %0d got %0d", x.m.kind, message_kind); errors++;
        end
        if (out_patch !== x.m.patch) begin
          $error("out_patch expected %0d got %0d", x.m.patch, out_patch); errors++;
        end
        if (out_note !== x.m.note) begin
          $error("out_note expected %0d got %0d", x.m.note, out_note); errors++;
        end
        if (out_velocity !== x.m.vel) begin
          $error("out_velocity expected %0d got %0d", x.m.vel, out_velocity); errors++;
        end
        if (last_of_run !== x.last) begin
          $error("last_of_run expected %0d got %0d", x.last, last_of_run); errors++;
        end
      end
    end
  end

  // watchdog on cycles without any request or message taken
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("tb_note_event_scheduler NOT OK");
        $finish;
      end
    end
  end

endmodule
